/* sv/gsc_pkg.sv */
// Package with shared types and constants for the column sweep block.
`timescale 1ns / 1ps
`default_nettype none
package gsc_pkg;
    localparam int MAX_ROWS = 1024;
    localparam int ADDR_W = $clog2(MAX_ROWS);

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_PIVOT = 2'd1,
        ACT_ENTRY = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DIAG = 2'd1,
        ST_RANGE    = 2'd2
    } status_t;

    localparam logic [0:0] REG_ROW_BASE  = 1'b0;
    localparam logic [0:0] REG_ROW_COUNT = 1'b1;

    // Divider handshake bundle.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend_hi; // residual; dividend is residual * 65536
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;   // already saturated to 32 bits
    } div_rsp_t;

    function automatic logic [31:0] sat32(input logic signed [49:0] v);
        logic [31:0] r;
        if (v > 50'sd2147483647) r = 32'h7FFF_FFFF;
        else if (v < -50'sd2147483648) r = 32'h8000_0000;
        else r = v[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

/* sv/gsc_divider.sv */
// Radix-2 restoring divider for the pivot quotient (residual * 65536) / diagonal.
`timescale 1ns / 1ps
`default_nettype none
module gsc_divider (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire gsc_pkg::div_req_t req,
    output gsc_pkg::div_rsp_t    rsp
);
    logic [47:0] num_reg, num_next;
    logic [48:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [48:0] trial;
    logic signed [49:0] sq;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[47:0], num_reg[47]} - {17'd0, den_reg};
        if (req.start)
        begin
            num_next  = {(req.dividend_hi[31] ? (~req.dividend_hi + 32'd1) : req.dividend_hi),
                         16'd0};
            den_next  = req.divisor[31] ? (~req.divisor + 32'd1) : req.divisor;
            neg_next  = req.dividend_hi[31] ^ req.divisor[31];
            rem_next  = '0;
            cnt_next  = 6'd48;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[48])
            begin
                rem_next = trial;
                num_next = {num_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[47:0], num_reg[47]};
                num_next = {num_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // Magnitude is below 2^48, so a 50-bit signed value holds it.
    assign sq = neg_reg ? -$signed({2'b00, num_reg}) : $signed({2'b00, num_reg});
    assign rsp.done = done_reg;
    assign rsp.quotient = gsc_pkg::sat32(sq);
endmodule
`default_nettype wire

/* sv/gauss_seidel_column_sweep.sv */
// Top level of the Gauss-Seidel column sweep: stores, sequencer and output register.
// Path after accept: an out-of-range row goes straight to the output register; load, read
// and zero diagonal pass through the read state; an off-diagonal entry goes through read,
// 32x32 multiply, subtract and write; a pivot waits on the bit-serial divider (48 steps).
// One beat is in flight at a time; input stalls until the result is taken.
// Reset clears control, last change and counter; the row stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module gauss_seidel_column_sweep (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [15:0] index,
    input  wire logic signed [31:0] value_a,
    input  wire logic signed [31:0] value_b,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic signed [31:0] solution_value,
    output logic signed [31:0] residual_value,
    output logic signed [31:0] change_value,
    output logic [15:0]      relax_count,
    output logic [1:0]       status,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int AW = gsc_pkg::ADDR_W;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_DIV, S_MUL, S_WRITE, S_OUT
    } state_t;

    // The two row stores live in synchronous memories with a registered read.
    logic [31:0] sol_mem [gsc_pkg::MAX_ROWS];
    logic [31:0] res_mem [gsc_pkg::MAX_ROWS];
    logic [31:0] sol_rd_reg, res_rd_reg;
    logic        we_sol, we_res;
    logic [31:0] wd_sol, wd_res;
    logic [AW-1:0] rd_addr_c;

    state_t      state_reg;
    logic [15:0] row_base_reg;
    logic [10:0] row_count_reg;
    logic [1:0]  act_reg;
    logic [AW-1:0] addr_reg;
    logic [31:0] va_reg, vb_reg;
    logic [31:0] change_reg;
    logic [15:0] count_reg;
    logic signed [63:0] prod_reg;
    logic        out_valid_reg;
    logic [31:0] out_sol_reg, out_res_reg;
    logic [1:0]  out_status_reg;

    gsc_pkg::div_req_t div_req;
    gsc_pkg::div_rsp_t div_rsp;

    logic [16:0] row_c;
    logic [11:0] limit_c;
    logic        row_ok_c;
    logic signed [49:0] new_sol_c, new_res_c;
    logic [31:0] sat_sol_w;
    logic signed [49:0] sat_sol_c;
    logic signed [49:0] diff_c;

    gsc_divider u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    // The row check is done at accept time on the raw beat.
    always_comb
    begin
        if (action == gsc_pkg::ACT_ENTRY)
            row_c = {1'b0, index} - {1'b0, row_base_reg};
        else
            row_c = {1'b0, index};
        limit_c  = (row_count_reg > 11'(gsc_pkg::MAX_ROWS)) ? 12'(gsc_pkg::MAX_ROWS)
                                                             : {1'b0, row_count_reg};
        row_ok_c = !row_c[16] && ({1'b0, row_c[15:0]} < {5'd0, limit_c});
    end

    assign in_stall = (state_reg != S_IDLE);

    // While idle the stores are addressed by the incoming row, so the row's data is
    // ready in the cycle after accept.
    assign rd_addr_c = (state_reg == S_IDLE) ? row_c[AW-1:0] : addr_reg;

    assign div_req.start       = (state_reg == S_READ) && (act_reg == gsc_pkg::ACT_PIVOT)
                                 && (va_reg != 32'd0);
    assign div_req.dividend_hi = res_rd_reg;
    assign div_req.divisor     = va_reg;

    assign new_sol_c = $signed({{18{sol_rd_reg[31]}}, sol_rd_reg})
                     + $signed({{18{div_rsp.quotient[31]}}, div_rsp.quotient});
    // Change is the saturated difference of the new and old solution.
    assign sat_sol_w = gsc_pkg::sat32(new_sol_c);
    assign sat_sol_c = $signed({{18{sat_sol_w[31]}}, sat_sol_w});
    assign diff_c = sat_sol_c - $signed({{18{sol_rd_reg[31]}}, sol_rd_reg});
    // Arithmetic shift floors the product; the result is below 2^48 in magnitude.
    assign new_res_c = $signed({{18{res_rd_reg[31]}}, res_rd_reg})
                     - $signed(prod_reg[63:16]);

    always_comb
    begin
        we_sol = 1'b0;
        we_res = 1'b0;
        wd_sol = va_reg;
        wd_res = vb_reg;
        if (state_reg == S_READ && act_reg == gsc_pkg::ACT_LOAD)
        begin
            we_sol = 1'b1;
            we_res = 1'b1;
        end
        else if (state_reg == S_DIV && div_rsp.done)
        begin
            we_sol = 1'b1;
            wd_sol = sat_sol_w;
        end
        else if (state_reg == S_WRITE)
        begin
            we_res = 1'b1;
            wd_res = gsc_pkg::sat32(new_res_c);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_sol) sol_mem[addr_reg] <= wd_sol;
        if (we_res) res_mem[addr_reg] <= wd_res;
        sol_rd_reg <= sol_mem[rd_addr_c];
        res_rd_reg <= res_mem[rd_addr_c];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            row_base_reg   <= '0;
            row_count_reg  <= '0;
            change_reg     <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            act_reg        <= gsc_pkg::ACT_LOAD;
            addr_reg       <= '0;
            va_reg         <= '0;
            vb_reg         <= '0;
            prod_reg       <= '0;
            out_sol_reg    <= '0;
            out_res_reg    <= '0;
            out_status_reg <= gsc_pkg::ST_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == gsc_pkg::REG_ROW_BASE) row_base_reg <= cfg_data;
                else row_count_reg <= cfg_data[10:0];
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        act_reg  <= action;
                        addr_reg <= row_c[AW-1:0];
                        va_reg   <= value_a;
                        vb_reg   <= value_b;
                        if (!row_ok_c)
                        begin
                            out_sol_reg    <= '0;
                            out_res_reg    <= '0;
                            out_status_reg <= gsc_pkg::ST_RANGE;
                            out_valid_reg  <= 1'b1;
                            state_reg      <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    // Read data is valid for the row now.
                    out_sol_reg    <= sol_rd_reg;
                    out_res_reg    <= res_rd_reg;
                    out_status_reg <= gsc_pkg::ST_OK;
                    unique case (act_reg)
                        gsc_pkg::ACT_LOAD:
                        begin
                            out_sol_reg   <= va_reg;
                            out_res_reg   <= vb_reg;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_OUT;
                        end
                        gsc_pkg::ACT_PIVOT:
                        begin
                            if (va_reg == 32'd0)
                            begin
                                out_status_reg <= gsc_pkg::ST_ZERO_DIAG;
                                out_valid_reg  <= 1'b1;
                                state_reg      <= S_OUT;
                            end
                            else
                            begin
                                state_reg <= S_DIV;
                            end
                        end
                        gsc_pkg::ACT_ENTRY: state_reg <= S_MUL;
                        default:
                        begin
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_OUT;
                        end
                    endcase
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        out_sol_reg   <= sat_sol_w;
                        change_reg    <= gsc_pkg::sat32(diff_c);
                        count_reg     <= count_reg + 16'd1;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= $signed(change_reg) * $signed(va_reg);
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    out_res_reg   <= gsc_pkg::sat32(new_res_c);
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign solution_value = out_sol_reg;
    assign residual_value = out_res_reg;
    assign change_value   = change_reg;
    assign relax_count    = count_reg;
    assign status         = out_status_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input accepted while busy");
    a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == S_OUT))
        else $error("result valid outside output state");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_DIV))
        else $error("counter changed outside a pivot");
`endif
endmodule
`default_nettype wire
